FILE: rtl/core/ritp_pkg.sv
// ritp_pkg: character codes and error codes for the regex infix-to-postfix block.
// No dependencies.
package ritp_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BAR    = 8'h7C;

	typedef enum logic [2:0] {
		ERR_NONE            = 3'd0,
		ERR_UNMATCHED_CLOSE = 3'd1,
		ERR_EMPTY_OPERAND   = 3'd2,
		ERR_UNCLOSED_OPEN   = 3'd3,
		ERR_TOO_DEEP        = 3'd4,
		ERR_TOO_MANY_ALTS   = 3'd5
	} err_code_t;

endpackage

FILE: rtl/core/ritp_ram.sv
// ritp_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ritp_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/regex_infix_to_postfix.sv
// regex_infix_to_postfix: converts a regex pattern, one byte per item, to postfix
// with explicit '.' concatenation. Depends on ritp_pkg and ritp_ram.
//
// Usage:
//   Input channel (symbol, end_of_pattern) with in_valid/in_stall; output channel
//   (out_symbol, error_code, last_of_run, pattern_done) with out_valid/out_stall.
//   Each input item yields zero or more result items; last_of_run marks the final
//   result of an item, pattern_done the final result of a whole pattern.
//   Per item: accept in S_IDLE, then the S_DECIDE state (the saved-count stack RAM
//   is read at accept and its data used in the decide cycle; a '(' writes it
//   back there), then S_EMIT, which loads the results into the output register
//   in turn, waiting while out_stall holds it. The next item is taken only after
//   the last result is loaded, or after S_DECIDE when an item has no result. A ')'
//   or the pattern end can produce up to 2*MAX_ALTS + 3 results.
//   A stalled receiver holds the output register; the emit sequence waits and
//   in_stall stays high until the last result of the run is in the output register.
//   On an error one flagged result is sent and later items are dropped up to and
//   including the pattern's last item. Reset clears counts, nest level and error
//   hold; the stack RAM needs no clearing.
module regex_infix_to_postfix #(
	parameter int STACK_DEPTH = 64,
	parameter int MAX_ALTS    = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       end_of_pattern,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_symbol,
	output logic [2:0] error_code,
	output logic       last_of_run,
	output logic       pattern_done
);

	import ritp_pkg::*;

	localparam int NW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int AL = $clog2(MAX_ALTS + 1);
	localparam int CW = $clog2(2 * MAX_ALTS + 5);
	localparam int SW = AL + 1;

	typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_EMIT} state_t;

	state_t          state_q;
	logic [7:0]      sym_q;
	logic            last_q;
	logic [1:0]      atom_q;
	logic [AL-1:0]   alt_q;
	logic [NW-1:0]   nest_q;
	logic            hold_q;

	err_code_t       err_q;
	logic            dot1_q;
	logic            sym_en_q;
	logic [AL-1:0]   alt1_q;
	logic            dot2_q;
	logic [AL-1:0]   alt2_q;
	logic [CW-1:0]   cnt_q;

	logic            out_valid_q;
	logic [7:0]      out_symbol_q;
	logic [2:0]      error_code_q;
	logic            last_of_run_q;
	logic            pattern_done_q;

	logic            accept;
	logic [NW-1:0]   nest_dec;
	logic            rd_en;
	logic [SW-1:0]   rd_data;
	logic            rd_atom;
	logic [AL-1:0]   rd_alt;
	logic            push;
	logic [SW-1:0]   push_data;

	err_code_t       t_err;
	err_code_t       f_err;
	err_code_t       d_err;
	logic            d_dot1;
	logic            d_sym_en;
	logic [AL-1:0]   d_alt1;
	logic            d_dot2;
	logic [AL-1:0]   d_alt2;
	logic            d_term;
	logic [1:0]      n_atom;
	logic [AL-1:0]   n_alt;
	logic [NW-1:0]   n_nest;
	logic [CW-1:0]   d_cnt;

	logic            out_load;
	logic [7:0]      pick_symbol;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign nest_dec = nest_q - 1'b1;
	assign rd_en    = accept && (symbol == CH_RPAREN);
	assign rd_atom  = rd_data[SW-1];
	assign rd_alt   = rd_data[AL-1:0];
	assign push_data = {atom_q[1] | atom_q[0], alt_q};

	ritp_ram #(
		.WIDTH (SW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (nest_q[AW-1:0]),
		.wr_data (push_data),
		.rd_en   (rd_en),
		.rd_addr (nest_dec[AW-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		t_err    = ERR_NONE;
		f_err    = ERR_NONE;
		d_dot1   = 1'b0;
		d_sym_en = 1'b0;
		d_alt1   = '0;
		d_dot2   = 1'b0;
		d_alt2   = '0;
		d_term   = 1'b0;
		n_atom   = atom_q;
		n_alt    = alt_q;
		n_nest   = nest_q;
		unique case (sym_q)
			CH_LPAREN: begin
				if (nest_q >= NW'(STACK_DEPTH)) begin
					t_err = ERR_TOO_DEEP;
				end else begin
					d_dot1 = atom_q[1];
					n_nest = nest_q + 1'b1;
					n_atom = 2'd0;
					n_alt  = '0;
				end
			end
			CH_BAR: begin
				if (atom_q == 2'd0) begin
					t_err = ERR_EMPTY_OPERAND;
				end else if (alt_q >= AL'(MAX_ALTS)) begin
					t_err = ERR_TOO_MANY_ALTS;
				end else begin
					d_dot1 = atom_q[1];
					n_atom = 2'd0;
					n_alt  = alt_q + 1'b1;
				end
			end
			CH_RPAREN: begin
				if (nest_q == '0) begin
					t_err = ERR_UNMATCHED_CLOSE;
				end else if (atom_q == 2'd0) begin
					t_err = ERR_EMPTY_OPERAND;
				end else begin
					d_dot1 = atom_q[1];
					d_alt1 = alt_q;
					n_nest = nest_dec;
					n_atom = {1'b0, rd_atom} + 2'd1;
					n_alt  = rd_alt;
				end
			end
			CH_STAR, CH_PLUS: begin
				if (atom_q == 2'd0) begin
					t_err = ERR_EMPTY_OPERAND;
				end else begin
					d_sym_en = 1'b1;
				end
			end
			default: begin
				d_dot1   = atom_q[1];
				d_sym_en = 1'b1;
				n_atom   = atom_q[1] ? 2'd2 : atom_q + 2'd1;
			end
		endcase
		if (t_err == ERR_NONE && last_q) begin
			if (n_nest != '0) begin
				f_err = ERR_UNCLOSED_OPEN;
			end else if (n_alt != '0 && n_atom == 2'd0) begin
				f_err = ERR_EMPTY_OPERAND;
			end else begin
				d_dot2 = n_atom[1];
				d_alt2 = n_alt;
				d_term = 1'b1;
			end
		end
		d_err = (t_err != ERR_NONE) ? t_err : f_err;
		if (d_err != ERR_NONE) begin
			d_cnt = CW'(1);
		end else begin
			d_cnt = CW'(d_dot1) + CW'(d_sym_en) + CW'(d_alt1) + CW'(d_dot2)
				+ CW'(d_alt2) + CW'(d_term);
		end
	end

	assign push = (state_q == S_DECIDE) && !hold_q && (sym_q == CH_LPAREN)
		&& (t_err == ERR_NONE);

	always_comb begin
		priority if (err_q != ERR_NONE) begin
			pick_symbol = CH_NUL;
		end else if (dot1_q) begin
			pick_symbol = CH_DOT;
		end else if (sym_en_q) begin
			pick_symbol = sym_q;
		end else if (alt1_q != '0) begin
			pick_symbol = CH_BAR;
		end else if (dot2_q) begin
			pick_symbol = CH_DOT;
		end else if (alt2_q != '0) begin
			pick_symbol = CH_BAR;
		end else begin
			pick_symbol = CH_NUL;
		end
	end

	assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sym_q          <= '0;
			last_q         <= 1'b0;
			atom_q         <= '0;
			alt_q          <= '0;
			nest_q         <= '0;
			hold_q         <= 1'b0;
			err_q          <= ERR_NONE;
			dot1_q         <= 1'b0;
			sym_en_q       <= 1'b0;
			alt1_q         <= '0;
			dot2_q         <= 1'b0;
			alt2_q         <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
			out_symbol_q   <= '0;
			error_code_q   <= '0;
			last_of_run_q  <= 1'b0;
			pattern_done_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q    <= 1'b1;
				out_symbol_q   <= pick_symbol;
				error_code_q   <= err_q;
				last_of_run_q  <= (cnt_q == CW'(1));
				pattern_done_q <= (cnt_q == CW'(1)) && last_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sym_q   <= symbol;
						last_q  <= end_of_pattern;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (hold_q) begin
						if (last_q) begin
							hold_q <= 1'b0;
							atom_q <= '0;
							alt_q  <= '0;
							nest_q <= '0;
						end
						state_q <= S_IDLE;
					end else begin
						err_q    <= d_err;
						dot1_q   <= d_dot1;
						sym_en_q <= d_sym_en;
						alt1_q   <= d_alt1;
						dot2_q   <= d_dot2;
						alt2_q   <= d_alt2;
						cnt_q    <= d_cnt;
						if (last_q) begin
							atom_q <= '0;
							alt_q  <= '0;
							nest_q <= '0;
						end else if (d_err != ERR_NONE) begin
							hold_q <= 1'b1;
						end else begin
							atom_q <= n_atom;
							alt_q  <= n_alt;
							nest_q <= n_nest;
						end
						state_q <= (d_cnt == '0) ? S_IDLE : S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						cnt_q <= cnt_q - 1'b1;
						// the terminator is the last result and clears nothing
						priority if (err_q != ERR_NONE) begin
							err_q <= ERR_NONE;
						end else if (dot1_q) begin
							dot1_q <= 1'b0;
						end else if (sym_en_q) begin
							sym_en_q <= 1'b0;
						end else if (alt1_q != '0) begin
							alt1_q <= alt1_q - 1'b1;
						end else if (dot2_q) begin
							dot2_q <= 1'b0;
						end else if (alt2_q != '0) begin
							alt2_q <= alt2_q - 1'b1;
						end
						if (cnt_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_symbol   = out_symbol_q;
	assign error_code   = error_code_q;
	assign last_of_run  = last_of_run_q;
	assign pattern_done = pattern_done_q;

endmodule
